FILE: rtl/core/assert_macros.svh
// Clocked assertion helpers, reset masked.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    `ASSERT_CLK(label, clk, rstn, (ante) |-> (cons))

`endif

FILE: rtl/core/rbsi_pkg.sv
package rbsi_pkg;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] entry_t;
        logic signed [31:0] exit_t;
    } out_t;

    localparam int EPS_W = 31;
    localparam logic [EPS_W-1:0] EPS_RESET = 31'd1;

endpackage

FILE: rtl/core/ray_box_slab_intersect.sv
// Throughput: one item per cycle unless the output stalls.
// Six slab divisions run as fully pipelined radix-2 dividers.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets the parallel epsilon eps_reg to 1.
`include "assert_macros.svh"

module ray_box_slab_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rbsi_pkg::EPS_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rbsi_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rbsi_pkg::out_t             m_data
);

    localparam int NQ = 33 + FRAC_BITS;
    localparam int TW = NQ + 1;
    localparam int LW = TW + 1;
    localparam int NL = 6;
    localparam logic signed [LW-1:0] LO_INIT = {2'b11, {(TW-1){1'b0}}};
    localparam logic signed [LW-1:0] HI_INIT = {2'b00, {(TW-1){1'b1}}};
    localparam logic signed [LW-1:0] SAT_MAX = {{(LW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [LW-1:0] SAT_MIN = {{(LW-31){1'b1}}, {31{1'b0}}};

    typedef struct packed {
        logic                 hit;
        logic signed [LW-1:0] lo;
        logic signed [LW-1:0] hi;
    } ax_t;

    function automatic ax_t axis_fn(input logic par, input logic pok,
                                    input logic signed [LW-1:0] t1,
                                    input logic signed [LW-1:0] t2,
                                    input ax_t cur);
        ax_t r;
        r = cur;
        if (cur.hit) begin
            if (par) begin
                r.hit = pok;
            end else if (t1 < cur.lo) begin
                r.hit = 1'b0;
            end else begin
                if (t1 <= cur.hi) begin
                    r.hi = t1;
                end
                if (t2 >= cur.lo) begin
                    if (t2 > r.hi) begin
                        r.hit = 1'b0;
                    end else begin
                        r.lo = t2;
                    end
                end
            end
        end
        return r;
    endfunction

    logic                       adv;
    logic [rbsi_pkg::EPS_W-1:0] eps_reg;
    rbsi_pkg::in_t              in_reg;
    logic                       in_v_reg;

    logic signed [31:0] org  [3];
    logic signed [31:0] dir  [3];
    logic signed [31:0] bmn  [3];
    logic signed [31:0] bmx  [3];
    logic [2:0]         par_next;
    logic [2:0]         pok_next;
    logic [NQ-1:0]      nq_next0  [NL];
    logic [31:0]        den_next0 [NL];
    logic [NL-1:0]      neg_next0;

    logic          dv_reg   [NQ+1];
    logic [2:0]    dpar_reg [NQ+1];
    logic [2:0]    dpok_reg [NQ+1];
    logic [31:0]   rem_reg  [NL][NQ+1];
    logic [NQ-1:0] nq_reg   [NL][NQ+1];
    logic [31:0]   den_reg  [NL][NQ+1];
    logic [NL-1:0] neg_reg  [NQ+1];
    logic [31:0]   rem_next [NL][NQ];
    logic [NQ-1:0] nq_next  [NL][NQ];

    logic                 tv_reg;
    logic [2:0]           tpar_reg;
    logic [2:0]           tpok_reg;
    logic signed [LW-1:0] t_reg [NL];

    logic                 av_reg   [3];
    logic [2:0]           apar_reg [2];
    logic [2:0]           apok_reg [2];
    logic signed [LW-1:0] at_reg   [2][NL];
    ax_t                  ax_reg   [3];
    ax_t                  ax_next  [3];

    logic           m_valid_reg;
    rbsi_pkg::out_t m_data_reg;
    rbsi_pkg::out_t m_data_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        logic signed [32:0] d33;
        logic signed [32:0] e33;
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic               dneg;
        logic               dpos;
        org = '{in_reg.origin_x, in_reg.origin_y, in_reg.origin_z};
        dir = '{in_reg.dir_x, in_reg.dir_y, in_reg.dir_z};
        bmn = '{in_reg.box_min_x, in_reg.box_min_y, in_reg.box_min_z};
        bmx = '{in_reg.box_max_x, in_reg.box_max_y, in_reg.box_max_z};
        e33 = $signed({2'b00, eps_reg});
        for (int a = 0; a < 3; a++) begin
            d33  = $signed({dir[a][31], dir[a]});
            dneg = d33 < -e33;
            dpos = d33 > e33;
            par_next[a] = !dneg && !dpos;
            pok_next[a] = !(org[a] < bmn[a] || org[a] > bmx[a]);
            for (int s = 0; s < 2; s++) begin
                // first bound is the far one for the ray's direction
                if (dneg == (s == 0)) begin
                    diff = $signed({bmn[a][31], bmn[a]}) - $signed({org[a][31], org[a]});
                end else begin
                    diff = $signed({bmx[a][31], bmx[a]}) - $signed({org[a][31], org[a]});
                end
                mag = diff[32] ? 33'(-diff) : 33'(diff);
                nq_next0[2*a+s]  = {mag, {FRAC_BITS{1'b0}}};
                den_next0[2*a+s] = dir[a][31] ? 32'(-dir[a]) : 32'(dir[a]);
                neg_next0[2*a+s] = diff[32] ^ dir[a][31];
            end
        end
    end

    always_comb begin
        logic [32:0] r2;
        for (int l = 0; l < NL; l++) begin
            for (int k = 0; k < NQ; k++) begin
                r2 = {rem_reg[l][k], nq_reg[l][k][NQ-1]};
                if (r2 >= {1'b0, den_reg[l][k]}) begin
                    rem_next[l][k] = 32'(r2 - {1'b0, den_reg[l][k]});
                    nq_next[l][k]  = {nq_reg[l][k][NQ-2:0], 1'b1};
                end else begin
                    rem_next[l][k] = r2[31:0];
                    nq_next[l][k]  = {nq_reg[l][k][NQ-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        ax_t start;
        start.hit = 1'b1;
        start.lo  = LO_INIT;
        start.hi  = HI_INIT;
        ax_next[0] = axis_fn(tpar_reg[0], tpok_reg[0], t_reg[0], t_reg[1], start);
        for (int a = 1; a < 3; a++) begin
            ax_next[a] = axis_fn(apar_reg[a-1][a], apok_reg[a-1][a],
                                 at_reg[a-1][2*a], at_reg[a-1][2*a+1], ax_reg[a-1]);
        end
    end

    always_comb begin
        m_data_next = '0;
        if (ax_reg[2].hit) begin
            m_data_next.hit = 1'b1;
            if (ax_reg[2].lo > SAT_MAX) begin
                m_data_next.entry_t = SAT_MAX[31:0];
            end else if (ax_reg[2].lo < SAT_MIN) begin
                m_data_next.entry_t = SAT_MIN[31:0];
            end else begin
                m_data_next.entry_t = ax_reg[2].lo[31:0];
            end
            if (ax_reg[2].hi > SAT_MAX) begin
                m_data_next.exit_t = SAT_MAX[31:0];
            end else if (ax_reg[2].hi < SAT_MIN) begin
                m_data_next.exit_t = SAT_MIN[31:0];
            end else begin
                m_data_next.exit_t = ax_reg[2].hi[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= rbsi_pkg::EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg    <= 1'b0;
            tv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= NQ; k++) begin
                dv_reg[k] <= 1'b0;
            end
            for (int a = 0; a < 3; a++) begin
                av_reg[a] <= 1'b0;
            end
        end else if (adv) begin
            in_v_reg  <= s_valid;
            dv_reg[0] <= in_v_reg;
            for (int k = 0; k < NQ; k++) begin
                dv_reg[k+1] <= dv_reg[k];
            end
            tv_reg    <= dv_reg[NQ];
            av_reg[0] <= tv_reg;
            for (int a = 1; a < 3; a++) begin
                av_reg[a] <= av_reg[a-1];
            end
            m_valid_reg <= av_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg      <= s_data;
            dpar_reg[0] <= par_next;
            dpok_reg[0] <= pok_next;
            neg_reg[0]  <= neg_next0;
            for (int l = 0; l < NL; l++) begin
                rem_reg[l][0] <= '0;
                nq_reg[l][0]  <= nq_next0[l];
                den_reg[l][0] <= den_next0[l];
            end
            for (int k = 0; k < NQ; k++) begin
                dpar_reg[k+1] <= dpar_reg[k];
                dpok_reg[k+1] <= dpok_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                for (int l = 0; l < NL; l++) begin
                    rem_reg[l][k+1] <= rem_next[l][k];
                    nq_reg[l][k+1]  <= nq_next[l][k];
                    den_reg[l][k+1] <= den_reg[l][k];
                end
            end
            tpar_reg <= dpar_reg[NQ];
            tpok_reg <= dpok_reg[NQ];
            for (int l = 0; l < NL; l++) begin
                if (neg_reg[NQ][l]) begin
                    t_reg[l] <= -$signed({2'b00, nq_reg[l][NQ]});
                end else begin
                    t_reg[l] <= $signed({2'b00, nq_reg[l][NQ]});
                end
            end
            apar_reg[0] <= tpar_reg;
            apok_reg[0] <= tpok_reg;
            at_reg[0]   <= t_reg;
            apar_reg[1] <= apar_reg[0];
            apok_reg[1] <= apok_reg[0];
            at_reg[1]   <= at_reg[0];
            for (int a = 0; a < 3; a++) begin
                ax_reg[a] <= ax_next[a];
            end
            m_data_reg <= m_data_next;
        end
    end

    `ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid && !m_data.hit,
                 m_data.entry_t == 32'sd0 && m_data.exit_t == 32'sd0)
    `ASSERT_IMPL(a_hit_ordered, aclk, aresetn, m_valid && m_data.hit,
                 m_data.entry_t <= m_data.exit_t)
    `ASSERT_IMPL(a_interval_ordered, aclk, aresetn, av_reg[2] && ax_reg[2].hit,
                 ax_reg[2].lo <= ax_reg[2].hi)

endmodule
